### rtl/core/fir_pkg.sv
// Shared constants, types and helper functions for the FIR filter block.
`timescale 1ns / 1ps
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS     = 63;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 18;
    localparam int FRAC_BITS    = 17;
    localparam int TAP_CNT_BITS = 6;
    localparam int IDX_BITS     = 6;

    localparam int PTR_BITS  = $clog2(MAX_TAPS);
    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS);

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RESET = TAP_CNT_BITS'(63);

    typedef logic [PTR_BITS-1:0] ptr_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic                          is_sample;
        logic                          coef_ok;
        ptr_t                          addr;
        logic signed [COEF_BITS-1:0]   coef;
        logic signed [SAMPLE_BITS-1:0] sample;
    } cmd_t;

    // Last tap index in use: even counts round up to odd, then clamp to the store.
    function automatic ptr_t last_tap(input logic [TAP_CNT_BITS-1:0] cnt);
        int t;
        t = int'(cnt) | 1;
        if (t > MAX_TAPS)
        begin
            t = MAX_TAPS;
        end
        return PTR_BITS'(t - 1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/fir_ifs.sv
// Handshake channel interfaces for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none

interface fir_req_if import fir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [IDX_BITS-1:0]           coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, func, coef_index, coef_value, sample_in, input ready);
    modport sink   (input valid, func, coef_index, coef_value, sample_in, output ready);
endinterface

interface fir_rsp_if import fir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

### rtl/core/fir_front.sv
// Front end: accept requests and classify them into queue commands.
`timescale 1ns / 1ps
`default_nettype none

module fir_front import fir_pkg::*;
(
    fir_req_if.sink req,
    input  wire logic q_full,
    output logic      push,
    output cmd_t      cmd
);

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        cmd.is_sample = (req.func == FUNC_SAMPLE);
        // drop loads aimed past the last tap
        cmd.coef_ok   = (32'(req.coef_index) < 32'(MAX_TAPS));
        cmd.addr      = PTR_BITS'(req.coef_index);
        cmd.coef      = req.coef_value;
        cmd.sample    = req.sample_in;
    end

endmodule

`default_nettype wire

### rtl/core/fir_queue.sv
// Short command queue between the front end and the MAC engine.
`timescale 1ns / 1ps
`default_nettype none

module fir_queue import fir_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      head_vld
);

    cmd_t                 entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_BITS'(QDEPTH));
    assign head_vld = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fir_back.sv
// Back end: sample and coefficient stores, shared multiply-accumulate, output register.
`timescale 1ns / 1ps
`default_nettype none

module fir_back import fir_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    head,
    input  wire logic                    head_vld,
    output logic                         pop,
    input  wire logic [TAP_CNT_BITS-1:0] tap_count,
    fir_rsp_if.source                    rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    localparam int QW = ACC_BITS - FRAC_BITS + 1;
    localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-(2 ** (SAMPLE_BITS - 1)));

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] a
    );
        logic signed [ACC_BITS:0] r;
        logic signed [QW-1:0]     q;
        r = (ACC_BITS + 1)'(a) + (ACC_BITS + 1)'(2 ** (FRAC_BITS - 1));
        q = QW'(r >>> FRAC_BITS);
        if (q > Q_MAX)
        begin
            q = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            q = Q_MIN;
        end
        return SAMPLE_BITS'(q);
    endfunction

    logic [1:0] state_reg, state_next;
    ptr_t       wp_reg, wp_next;
    ptr_t       k_reg, k_next;
    ptr_t       h_reg, h_next;
    ptr_t       last_reg, last_next;

    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           hv_reg;
    logic [MAX_TAPS-1:0]           cv_reg;

    logic signed [SAMPLE_BITS-1:0] hist_rd_reg;
    logic signed [COEF_BITS-1:0]   coef_rd_reg;
    logic                          hv_rd_reg;
    logic                          cv_rd_reg;
    logic                          s1_vld_reg;
    logic                          s2_vld_reg;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] coef_op;
    logic signed [COEF_BITS-1:0]   coef_wide;

    logic                          out_vld_reg, out_vld_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    logic issue;
    logic start;
    logic coef_wr;
    logic pipe_empty;
    logic load_out;

    assign issue      = (state_reg == S_RUN);
    assign pop        = (state_reg == S_IDLE) && head_vld;
    assign start      = pop && head.is_sample;
    assign coef_wr    = pop && !head.is_sample && head.coef_ok;
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign load_out   = (state_reg == S_DRAIN) && pipe_empty && (!out_vld_reg || rsp.ready);

    assign rsp.valid      = out_vld_reg;
    assign rsp.sample_out = out_data_reg;

    // Never-written entries read as zero.
    assign coef_wide = cv_rd_reg ? coef_rd_reg : '0;
    assign coef_op   = hv_rd_reg ? hist_rd_reg : '0;
    assign prod_next = coef_wide * coef_op;

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        k_next     = k_reg;
        h_next     = h_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    wp_next    = (wp_reg == PTR_BITS'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
                    h_next     = wp_reg;
                    k_next     = '0;
                    last_next  = last_tap(tap_count);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                k_next = k_reg + 1'b1;
                h_next = (h_reg == '0) ? PTR_BITS'(MAX_TAPS - 1) : h_reg - 1'b1;
                if (k_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (start)
        begin
            acc_next = '0;
        end
        else if (s2_vld_reg)
        begin
            acc_next = acc_reg + ACC_BITS'(prod_reg);
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_vld_next  = 1'b1;
            out_data_next = round_sat(acc_reg);
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            k_reg       <= '0;
            h_reg       <= '0;
            last_reg    <= '0;
            hv_reg      <= '0;
            cv_reg      <= '0;
            hv_rd_reg   <= 1'b0;
            cv_rd_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            k_reg       <= k_next;
            h_reg       <= h_next;
            last_reg    <= last_next;
            s1_vld_reg  <= issue;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= out_vld_next;
            if (start)
            begin
                hv_reg[wp_reg] <= 1'b1;
            end
            if (coef_wr)
            begin
                cv_reg[head.addr] <= 1'b1;
            end
            if (issue)
            begin
                hv_rd_reg <= hv_reg[h_reg];
                cv_rd_reg <= cv_reg[k_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hist_mem[wp_reg] <= head.sample;
        end
        if (issue)
        begin
            hist_rd_reg <= hist_mem[h_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[head.addr] <= head.coef;
        end
        if (issue)
        begin
            coef_rd_reg <= coef_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg <= last_reg))
        else $error("tap index ran past the last tap");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("queue popped while engine busy");

    a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (pipe_empty && !issue))
        else $error("result loaded before accumulation finished");

    a_pipe_follow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("product stage valid without a read");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !rsp.ready) |=> out_vld_reg)
        else $error("pending result dropped");

endmodule

`default_nettype wire

### rtl/core/fir_filter_circular_history_unit.sv
// Top level of the direct-form FIR filter with circular sample history.
//
// Usage:
//   req  - request channel (valid/ready). func selects a coefficient load
//          (write coef_value at coef_index, no response; indexes past the last
//          tap are dropped) or a sample (filter sample_in, one response).
//   rsp  - response channel (valid/ready) carrying sample_out, rounded half up
//          from Q.17 and saturated to signed 16 bits.
//   cfg  - cfg_we/cfg_wdata write tap_count; even counts round up to odd.
//          Write only while the block is idle.
// Flow: the MAC engine works through the taps of a sample one at a time, and
// it takes no new request until that sample's sum is loaded into the output
// register. The single shared multiplier, fed from one read port per store,
// is why the taps are worked through in turn.
// Requests land in a two-entry queue, so the front keeps taking requests while
// the engine works. A stalled receiver holds the output register; the engine
// then waits with its finished sum and the queue fills, dropping req.ready.
// Reset: tap_count = 63, history and coefficients read as zero (output zero).
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_circular_history_unit import fir_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    fir_req_if.sink                      req,
    fir_rsp_if.source                    rsp,
    input  wire logic                    cfg_we,
    input  wire logic [TAP_CNT_BITS-1:0] cfg_wdata
);

    logic [TAP_CNT_BITS-1:0] tap_count_reg;

    logic push;
    logic q_full;
    logic pop;
    logic head_vld;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Hold the tap count register; the engine samples it at the start of each sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_CNT_RESET;
        end
        else if (cfg_we)
        begin
            tap_count_reg <= cfg_wdata;
        end
    end

    // Classify incoming requests.
    fir_front u_front
    (
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    // Decouple the front from the MAC engine.
    fir_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head      (head_cmd),
        .head_vld  (head_vld)
    );

    // Store, multiply-accumulate over taps, round and saturate.
    fir_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .head_vld  (head_vld),
        .pop       (pop),
        .tap_count (tap_count_reg),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
